@@ rtl/lscd_pkg.sv @@
// shared types, constants and codes of the lru slot cache directory
`default_nettype none
package lscd_pkg;
   localparam int SLOTS_DEF = 1024;
   localparam int BYTES_PER_VALUE_DEF = 4;
   localparam logic [19:0] MEGA = 20'd1000000;
   localparam logic [19:0] LIMIT_RESET = 20'd1000;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] lookup_key;
      logic [31:0] entry_length;
   } req_type;

   typedef struct packed {
      logic [31:0] assigned_key;
      logic        found;
      logic [31:0] found_length;
      logic [41:0] stored_values;
      logic [31:0] hit_count;
      logic [31:0] miss_count;
      logic [31:0] insert_count;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] key;
      logic [31:0] length;
      logic [63:0] stamp;
   } slot_type;

   typedef enum logic [3:0] {
      CMD_NONE, CMD_CLR, CMD_LOAD, CMD_MOD, CMD_RD, CMD_LK_EVAL, CMD_OLD_INIT,
      CMD_OLD_RD, CMD_OLD_EVAL, CMD_OLD_EVICT, CMD_FIND_INIT, CMD_FIND_RD,
      CMD_FIND_EVAL, CMD_FIND_PICK, CMD_INS, CMD_RESP
   } cmd_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_MOD, S_LK_RD, S_LK_EVAL, S_CHECK, S_OLD_RD,
      S_OLD_EVAL, S_OLD_EVICT, S_FIND_INIT, S_FIND_RD, S_FIND_EVAL, S_FIND_PICK,
      S_FIN_RD, S_INS_RESP
   } state_type;

   typedef struct packed {
      logic       last;
      logic       free_hit;
      logic       pick_found;
      logic       over_limit;
      logic       mod_done;
      logic [1:0] op;
      logic       len_zero;
      logic       rsp_free;
   } status_type;
endpackage
`default_nettype wire

@@ rtl/lscd_ctrl.sv @@
// controller state machine of the lru slot cache directory
`default_nettype none
module lscd_ctrl
   import lscd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);
   state_type state_ff, state_in;
   logic resp_pending_ff, resp_pending_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         resp_pending_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         resp_pending_ff <= resp_pending_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      resp_pending_in = resp_pending_ff;
      cmd = CMD_NONE;
      req_stall = 1'b1;
      unique case (state_ff)
         S_CLEAR: begin
            cmd = CMD_CLR;
            if (status.last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd = CMD_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (status.op == OP_INSERT && !status.len_zero) begin
               state_in = S_CHECK;
            end else if (status.op == OP_LOOKUP || status.op == OP_DELETE) begin
               state_in = S_MOD;
            end else begin
               state_in = S_INS_RESP;
               resp_pending_in = 1'b1;
            end
         end
         S_MOD: begin
            cmd = CMD_MOD;
            if (status.mod_done) state_in = S_LK_RD;
         end
         S_LK_RD: begin
            cmd = CMD_RD;
            state_in = S_LK_EVAL;
         end
         S_LK_EVAL: begin
            cmd = CMD_LK_EVAL;
            state_in = S_INS_RESP;
            resp_pending_in = 1'b1;
         end
         S_CHECK: begin
            cmd = CMD_OLD_INIT;
            state_in = status.over_limit ? S_OLD_RD : S_FIND_INIT;
         end
         S_OLD_RD: begin
            cmd = CMD_OLD_RD;
            state_in = S_OLD_EVAL;
         end
         S_OLD_EVAL: begin
            cmd = CMD_OLD_EVAL;
            state_in = status.last ? S_OLD_EVICT : S_OLD_RD;
         end
         S_OLD_EVICT: begin
            if (status.pick_found) begin
               cmd = CMD_OLD_EVICT;
               state_in = S_CHECK;
            end else begin
               state_in = S_FIND_INIT;
            end
         end
         S_FIND_INIT: begin
            cmd = CMD_FIND_INIT;
            state_in = S_FIND_RD;
         end
         S_FIND_RD: begin
            cmd = CMD_FIND_RD;
            state_in = S_FIND_EVAL;
         end
         S_FIND_EVAL: begin
            cmd = CMD_FIND_EVAL;
            priority if (status.free_hit) state_in = S_FIN_RD;
            else if (status.last) state_in = S_FIND_PICK;
            else state_in = S_FIND_RD;
         end
         S_FIND_PICK: begin
            cmd = CMD_FIND_PICK;
            state_in = S_FIN_RD;
         end
         S_FIN_RD: begin
            cmd = CMD_RD;
            state_in = S_INS_RESP;
         end
         S_INS_RESP: begin
            // for an insert, store it first; then hand the item over when the output frees up
            if (!resp_pending_ff) begin
               cmd = CMD_INS;
               resp_pending_in = 1'b1;
            end else if (status.rsp_free) begin
               cmd = CMD_RESP;
               resp_pending_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

@@ rtl/lscd_dpath.sv @@
// datapath of the lru slot cache directory: slot memory, scans, key modulo, counters
`default_nettype none
module lscd_dpath
   import lscd_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF,
   parameter int BYTES_PER_VALUE = BYTES_PER_VALUE_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output status_type       status,
   input  wire req_type     req_data,
   output rsp_type          rsp_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        csr_we,
   input  wire logic [19:0] csr_wdata
);
   localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TOTW = 32 + IDXW;
   localparam int CW = (TOTW + 4 > 40) ? TOTW + 4 : 40;
   localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);
   localparam logic [IDXW:0] SLOTS_W = (IDXW + 1)'(SLOTS);
   // reciprocal of the slot count, scaled by 2^(32+IDXW)
   localparam logic [32:0] RECIP = 33'((64'd1 << (32 + IDXW)) / 64'(SLOTS));
   localparam logic [15:0] RECIP_LO = RECIP[15:0];
   localparam logic [16:0] RECIP_HI = RECIP[32:16];

   slot_type mem [SLOTS];
   slot_type rd_ff;
   logic mem_we;
   logic [IDXW-1:0] mem_wa, mem_ra;
   slot_type mem_wd;

   req_type req_ff, req_in;
   logic [IDXW-1:0] idx_ff, idx_in, scan_ff, scan_in, pick_ff, pick_in;
   logic [IDXW-1:0] fidx_ff, fidx_in, key_idx_ff, key_idx_in, fidx_next;
   logic [1:0] bit_ff, bit_in;
   logic [63:0] best_ff, best_in, access_ff, access_in;
   logic [31:0] pick_len_ff, pick_len_in, pick_key_ff, pick_key_in;
   logic [31:0] fkey_ff, fkey_in, final_key_ff, final_key_in, key_ctr_ff, key_ctr_in;
   logic pick_found_ff, pick_found_in;
   logic [TOTW-1:0] total_ff, total_in;
   logic [31:0] hits_ff, hits_in, misses_ff, misses_in, inserts_ff, inserts_in;
   logic [19:0] limit_ff;
   logic [39:0] limit_bytes_ff;
   logic [31:0] assigned_ff, assigned_in, flen_ff, flen_in;
   logic found_ff, found_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [47:0] mul_lo_ff, mul_lo_in;
   logic [48:0] mul_hi_ff, mul_hi_in;
   logic [64:0] prod_sum;
   logic [31:0] quot_ff, quot_in;
   logic [IDXW:0] rem_ff, rem_in;
   logic match;

   // next probe slot; the key wrap at 2^32 restarts at slot zero
   assign fidx_next = (fidx_ff == LAST_IDX || fkey_ff == 32'hFFFF_FFFF) ? '0
                    : fidx_ff + 1'b1;
   assign match = rd_ff.valid && rd_ff.key == req_ff.lookup_key;

   // key modulo slots by reciprocal multiplication, in registered stages: products, quotient, remainder
   assign mul_lo_in = 48'(req_ff.lookup_key) * 48'(RECIP_LO);
   assign mul_hi_in = 49'(req_ff.lookup_key) * 49'(RECIP_HI);
   assign prod_sum = {mul_hi_ff, 16'd0} + 65'(mul_lo_ff);
   assign quot_in = 32'(prod_sum >> (32 + IDXW));
   // quotient estimate is at most one low, so the remainder is below twice slots
   assign rem_in = (IDXW + 1)'(req_ff.lookup_key) - (IDXW + 1)'(quot_ff * 32'(SLOTS));

   // status back to the controller
   always_comb begin
      status.last = (scan_ff == LAST_IDX);
      status.free_hit = !rd_ff.valid;
      status.pick_found = pick_found_ff;
      status.over_limit = (CW'(total_ff) * CW'(BYTES_PER_VALUE)) > CW'(limit_bytes_ff);
      status.mod_done = (bit_ff == 2'd0);
      status.op = req_ff.opcode;
      status.len_zero = (req_ff.entry_length == 32'd0);
      status.rsp_free = !rsp_valid_ff || !rsp_stall;
   end

   // memory address and write selection
   always_comb begin
      mem_we = 1'b0;
      mem_wa = idx_ff;
      mem_wd = rd_ff;
      mem_ra = idx_ff;
      unique case (cmd)
         CMD_CLR: begin
            mem_we = 1'b1;
            mem_wa = scan_ff;
            mem_wd.valid = 1'b0;
         end
         CMD_LK_EVAL: begin
            mem_we = match && (req_ff.opcode == OP_LOOKUP || req_ff.opcode == OP_DELETE);
            if (req_ff.opcode == OP_LOOKUP) mem_wd.stamp = access_ff;
            else mem_wd.valid = 1'b0;
         end
         CMD_OLD_RD: mem_ra = scan_ff;
         CMD_OLD_EVICT: begin
            mem_we = 1'b1;
            mem_wa = pick_ff;
            mem_wd.valid = 1'b0;
         end
         CMD_FIND_RD: mem_ra = fidx_next;
         CMD_INS: begin
            mem_we = 1'b1;
            mem_wd.valid = 1'b1;
            mem_wd.key = final_key_ff;
            mem_wd.length = req_ff.entry_length;
            mem_wd.stamp = access_ff;
         end
         default: ;
      endcase
   end

   // slot memory
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_ff <= mem[mem_ra];
   end

   // next values of the datapath registers
   always_comb begin
      req_in = req_ff;
      idx_in = idx_ff;
      scan_in = scan_ff;
      pick_in = pick_ff;
      fidx_in = fidx_ff;
      key_idx_in = key_idx_ff;
      bit_in = bit_ff;
      best_in = best_ff;
      access_in = access_ff;
      pick_len_in = pick_len_ff;
      pick_key_in = pick_key_ff;
      fkey_in = fkey_ff;
      final_key_in = final_key_ff;
      key_ctr_in = key_ctr_ff;
      pick_found_in = pick_found_ff;
      total_in = total_ff;
      hits_in = hits_ff;
      misses_in = misses_ff;
      inserts_in = inserts_ff;
      assigned_in = assigned_ff;
      flen_in = flen_ff;
      found_in = found_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (cmd)
         CMD_CLR: scan_in = scan_ff + 1'b1;
         CMD_LOAD: begin
            req_in = req_data;
            idx_in = '0;
            bit_in = 2'd2;
            assigned_in = '0;
            flen_in = '0;
            found_in = 1'b0;
         end
         CMD_MOD: begin
            // final correction of the remainder into the table range
            idx_in = (rem_ff >= SLOTS_W) ? IDXW'(rem_ff - SLOTS_W) : IDXW'(rem_ff);
            bit_in = bit_ff - 1'b1;
         end
         CMD_LK_EVAL: begin
            if (req_ff.opcode == OP_LOOKUP) begin
               if (match) begin
                  hits_in = hits_ff + 1'b1;
                  found_in = 1'b1;
                  flen_in = rd_ff.length;
                  access_in = access_ff + 1'b1;
               end else begin
                  misses_in = misses_ff + 1'b1;
               end
            end else if (match) begin
               found_in = 1'b1;
               total_in = total_ff - TOTW'(rd_ff.length);
            end
         end
         CMD_OLD_INIT: begin
            best_in = access_ff;
            pick_found_in = 1'b0;
            scan_in = '0;
         end
         CMD_OLD_EVAL: begin
            if (rd_ff.valid && rd_ff.stamp < best_ff) begin
               best_in = rd_ff.stamp;
               pick_in = scan_ff;
               pick_len_in = rd_ff.length;
               pick_found_in = 1'b1;
            end
            scan_in = scan_ff + 1'b1;
         end
         CMD_OLD_EVICT: total_in = total_ff - TOTW'(pick_len_ff);
         CMD_FIND_INIT: begin
            best_in = access_ff;
            scan_in = '0;
            fkey_in = key_ctr_ff;
            fidx_in = key_idx_ff;
            pick_key_in = '0;
            pick_in = '0;
         end
         CMD_FIND_RD: begin
            fkey_in = fkey_ff + 1'b1;
            fidx_in = fidx_next;
         end
         CMD_FIND_EVAL: begin
            // free slot ends the scan, else track the oldest
            if (!rd_ff.valid) begin
               idx_in = fidx_ff;
               final_key_in = fkey_ff;
            end else if (rd_ff.stamp < best_ff) begin
               best_in = rd_ff.stamp;
               pick_in = fidx_ff;
               pick_key_in = fkey_ff;
            end
            scan_in = scan_ff + 1'b1;
         end
         CMD_FIND_PICK: begin
            idx_in = pick_ff;
            final_key_in = pick_key_ff;
         end
         CMD_INS: begin
            total_in = total_ff - (rd_ff.valid ? TOTW'(rd_ff.length) : '0)
                     + TOTW'(req_ff.entry_length);
            access_in = access_ff + 1'b1;
            inserts_in = inserts_ff + 1'b1;
            key_ctr_in = final_key_ff;
            key_idx_in = idx_ff;
            assigned_in = final_key_ff;
         end
         CMD_RESP: begin
            rsp_in.assigned_key = assigned_ff;
            rsp_in.found = found_ff;
            rsp_in.found_length = flen_ff;
            rsp_in.stored_values = 42'(total_ff);
            rsp_in.hit_count = hits_ff;
            rsp_in.miss_count = misses_ff;
            rsp_in.insert_count = inserts_ff;
            rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   // control and counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
         key_idx_ff <= '0;
         access_ff <= '0;
         key_ctr_ff <= '0;
         total_ff <= '0;
         hits_ff <= '0;
         misses_ff <= '0;
         inserts_ff <= '0;
         pick_found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff <= LIMIT_RESET;
         limit_bytes_ff <= 40'(LIMIT_RESET) * 40'(MEGA);
      end else begin
         scan_ff <= scan_in;
         key_idx_ff <= key_idx_in;
         access_ff <= access_in;
         key_ctr_ff <= key_ctr_in;
         total_ff <= total_in;
         hits_ff <= hits_in;
         misses_ff <= misses_in;
         inserts_ff <= inserts_in;
         pick_found_ff <= pick_found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) limit_ff <= csr_wdata;
         limit_bytes_ff <= 40'(limit_ff) * 40'(MEGA);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      idx_ff <= idx_in;
      pick_ff <= pick_in;
      fidx_ff <= fidx_in;
      bit_ff <= bit_in;
      best_ff <= best_in;
      pick_len_ff <= pick_len_in;
      pick_key_ff <= pick_key_in;
      fkey_ff <= fkey_in;
      final_key_ff <= final_key_in;
      assigned_ff <= assigned_in;
      flen_ff <= flen_in;
      found_ff <= found_in;
      rsp_ff <= rsp_in;
      mul_lo_ff <= mul_lo_in;
      mul_hi_ff <= mul_hi_in;
      quot_ff <= quot_in;
      rem_ff <= rem_in;
   end

   assign rsp_data = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   // key counter slot index stays inside the table
   a_key_idx: assert property (@(posedge clock) disable iff (reset)
      key_idx_ff <= LAST_IDX) else $error("key index out of range");
   // an insert advances the access stamp by one
   a_ins_stamp: assert property (@(posedge clock) disable iff (reset)
      cmd == CMD_INS |=> access_ff == $past(access_ff) + 64'd1) else $error("stamp slip");
   // a result is loaded only into a free output register
   a_resp_free: assert property (@(posedge clock) disable iff (reset)
      cmd == CMD_RESP |-> (!rsp_valid_ff || !rsp_stall)) else $error("result overrun");
endmodule
`default_nettype wire

@@ rtl/lru_slot_cache_directory_core.sv @@
// lookup and delete: key modulo, then slot read and evaluate; an unused opcode or empty insert skips to the result
// insert: the free-slot scan reads and evaluates slot by slot from the key counter slot,
// after one size-limit eviction pass over the slot memory for each eviction while over the limit
// one item at a time through the slot memory; result is registered
// reset: synchronous; a clearing pass marks every slot invalid,
// with no item accepted until it ends
`default_nettype none
module lru_slot_cache_directory_core
   import lscd_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF,
   parameter int BYTES_PER_VALUE = BYTES_PER_VALUE_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic [19:0] csr_wdata
);
   cmd_type cmd;
   status_type status;

   // sequencer
   lscd_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .status(status), .cmd(cmd)
   );

   // slot memory and arithmetic
   lscd_dpath #(.SLOTS(SLOTS), .BYTES_PER_VALUE(BYTES_PER_VALUE)) u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status), .req_data(req_data),
      .rsp_data(rsp_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );
endmodule
`default_nettype wire

@@ verif/lru_slot_cache_directory_core_tb.sv @@
// testbench of the lru slot cache directory core: directed and random items against a predictor
`default_nettype none
module lru_slot_cache_directory_core_tb
   import lscd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SLOTS = 1024;
   localparam int VALUE_BYTES = 4;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 10000000;
   localparam int RANDOM_ITEMS = 265;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_we;
   logic [19:0] csr_wdata;

   // predictor copy of the directory
   logic dir_valid [NUM_SLOTS];
   logic [31:0] dir_key [NUM_SLOTS];
   logic [31:0] dir_length [NUM_SLOTS];
   logic [63:0] dir_stamp [NUM_SLOTS];
   logic [63:0] stamp_now;
   logic [31:0] last_key;
   logic [63:0] held_values;
   logic [31:0] hit_total;
   logic [31:0] miss_total;
   logic [31:0] insert_total;
   logic [19:0] limit_mb;

   rsp_type pending_rsp[$];
   logic [31:0] issued_keys[$];
   int mismatches;
   int idle_cycles;
   bit send_no_gap;
   bit sink_no_stall;
   int stall_left;

   lru_slot_cache_directory_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // drop a slot and its values from the stored total
   task automatic drop_slot(input int i);
      if (dir_valid[i]) begin
         held_values = held_values - dir_length[i];
         dir_valid[i] = 1'b0;
      end
   endtask

   // evict the least recently stamped valid slot; 0 when none is older than now
   task automatic evict_lru(output bit evicted);
      logic [63:0] oldest;
      int pick;
      oldest = stamp_now;
      pick = -1;
      for (int t = 0; t < NUM_SLOTS; t++) begin
         if (dir_valid[t] && dir_stamp[t] < oldest) begin
            oldest = dir_stamp[t];
            pick = t;
         end
      end
      evicted = (pick >= 0);
      if (evicted) drop_slot(pick);
   endtask

   // step the key forward to a free slot, else take the oldest scanned slot
   task automatic next_free_key(output logic [31:0] k);
      logic [63:0] oldest;
      logic [31:0] probe;
      logic [31:0] pick_key;
      int pick;
      int i;
      oldest = stamp_now;
      pick = -1;
      pick_key = '0;
      probe = last_key;
      for (int t = 0; t < NUM_SLOTS; t++) begin
         probe = probe + 32'd1;
         i = probe % NUM_SLOTS;
         if (!dir_valid[i]) begin
            k = probe;
            return;
         end
         if (dir_stamp[i] < oldest) begin
            oldest = dir_stamp[i];
            pick = i;
            pick_key = probe;
         end
      end
      if (pick >= 0) drop_slot(pick);
      k = pick_key;
   endtask

   // expected result of one item, updating the predictor state
   task automatic predict_directory(input req_type r, output rsp_type e);
      logic [63:0] limit_bytes;
      logic [31:0] k;
      bit evicted;
      int i;
      e = '0;
      if (r.opcode == OP_INSERT) begin
         if (r.entry_length != 0) begin
            limit_bytes = 64'(limit_mb) * 64'd1000000;
            while (held_values * VALUE_BYTES > limit_bytes) begin
               evict_lru(evicted);
               if (!evicted) break;
            end
            next_free_key(k);
            last_key = k;
            i = k % NUM_SLOTS;
            drop_slot(i);
            dir_valid[i] = 1'b1;
            dir_key[i] = k;
            dir_length[i] = r.entry_length;
            dir_stamp[i] = stamp_now;
            stamp_now = stamp_now + 64'd1;
            held_values = held_values + r.entry_length;
            insert_total = insert_total + 32'd1;
            e.assigned_key = k;
            issued_keys.push_back(k);
         end
      end else if (r.opcode == OP_LOOKUP || r.opcode == OP_DELETE) begin
         i = r.lookup_key % NUM_SLOTS;
         if (dir_valid[i] && dir_key[i] == r.lookup_key) begin
            e.found = 1'b1;
            if (r.opcode == OP_LOOKUP) begin
               hit_total = hit_total + 32'd1;
               e.found_length = dir_length[i];
               dir_stamp[i] = stamp_now;
               stamp_now = stamp_now + 64'd1;
            end else begin
               drop_slot(i);
            end
         end else if (r.opcode == OP_LOOKUP) begin
            miss_total = miss_total + 32'd1;
         end
      end
      e.stored_values = held_values[41:0];
      e.hit_count = hit_total;
      e.miss_count = miss_total;
      e.insert_count = insert_total;
   endtask

   // send one item after a random gap and predict its result on acceptance
   // valid stays high after acceptance until the next gap or drain lowers it
   task automatic send_item(input logic [1:0] op, input logic [31:0] k, input logic [31:0] len);
      req_type r;
      rsp_type e;
      int gap;
      gap = send_no_gap ? 0 : $urandom_range(0, 14);
      r.opcode = op;
      r.lookup_key = k;
      r.entry_length = len;
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_directory(r, e);
      pending_rsp.push_back(e);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_limit(input logic [19:0] v);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      limit_mb = v;
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] known_key();
      if (issued_keys.size() == 0) return $urandom();
      return issued_keys[$urandom_range(0, issued_keys.size() - 1)];
   endfunction

   // field extremes, every opcode and the empty insert
   task automatic test_directed();
      send_item(OP_INSERT, 32'h0, 32'h0);
      send_item(OP_INSERT, 32'hFFFF_FFFF, 32'd1);
      send_item(OP_INSERT, 32'h0, 32'hFFFF_FFFF);
      send_item(OP_LOOKUP, 32'd1, 32'h0);
      send_item(OP_LOOKUP, 32'd2, 32'hFFFF_FFFF);
      send_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
      send_item(OP_LOOKUP, 32'd1 + NUM_SLOTS, 32'h0);
      send_item(OP_LOOKUP, 32'h0, 32'h0);
      send_item(OP_UNUSED, 32'd1, 32'hFFFF_FFFF);
      send_item(OP_UNUSED, 32'hFFFF_FFFF, 32'h0);
      send_item(OP_DELETE, 32'd1 + NUM_SLOTS, 32'h0);
      send_item(OP_DELETE, 32'd1, 32'hFFFF_FFFF);
      send_item(OP_DELETE, 32'd1, 32'h0);
      send_item(OP_LOOKUP, 32'd1, 32'h0);
      // the oversized entry forces a size-limit eviction on the next insert
      send_item(OP_INSERT, 32'h0, 32'd7);
      send_item(OP_LOOKUP, 32'd2, 32'h0);
   endtask

   // zero limit evicts everything older before each insert
   task automatic test_limit_zero();
      set_limit(20'd0);
      send_no_gap = 1'b1;
      for (int n = 0; n < 6; n++) send_item(OP_INSERT, $urandom(), $urandom_range(1, 50));
      send_item(OP_LOOKUP, known_key(), 32'h0);
      send_no_gap = 1'b0;
      set_limit(20'hFFFFF);
      for (int n = 0; n < 4; n++) send_item(OP_INSERT, 32'h0, $urandom());
      send_item(OP_LOOKUP, known_key(), 32'h0);
   endtask

   // random traffic, mostly on keys that were handed out
   task automatic test_random();
      logic [31:0] len;
      int pick;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 60) set_limit(20'd1);
         if (n == 130) set_limit(LIMIT_RESET);
         if (n == 200) set_limit(20'($urandom_range(2, 20'hFFFFE)));
         send_no_gap = (n >= 90 && n < 110);
         sink_no_stall = (n >= 100 && n < 120);
         if (n == 150) wait_drained();
         pick = $urandom_range(0, 19);
         len = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 300);
         if (pick < 8) send_item(OP_INSERT, $urandom(), len);
         else if (pick < 14) send_item(OP_LOOKUP,
               ($urandom_range(0, 3) == 0) ? $urandom() : known_key(), $urandom());
         else if (pick < 18) send_item(OP_DELETE,
               ($urandom_range(0, 3) == 0) ? $urandom() : known_key(), $urandom());
         else send_item(OP_UNUSED, $urandom(), $urandom());
      end
   endtask

   // result sink: random stall per item and the compare against the oldest expectation
   always @(posedge clock) begin
      rsp_type e;
      int n;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_data);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_data.assigned_key !== e.assigned_key || rsp_data.found !== e.found
                  || rsp_data.found_length !== e.found_length
                  || rsp_data.stored_values !== e.stored_values
                  || rsp_data.hit_count !== e.hit_count
                  || rsp_data.miss_count !== e.miss_count
                  || rsp_data.insert_count !== e.insert_count) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch key %h/%h found %b/%b flen %h/%h stored %h/%h",
                     e.assigned_key, rsp_data.assigned_key, e.found, rsp_data.found,
                     e.found_length, rsp_data.found_length,
                     e.stored_values, rsp_data.stored_values);
                  $display("   hits %h/%h misses %h/%h inserts %h/%h",
                     e.hit_count, rsp_data.hit_count, e.miss_count, rsp_data.miss_count,
                     e.insert_count, rsp_data.insert_count);
               end
            end
         end
         n = sink_no_stall ? 0 : $urandom_range(0, 14);
         stall_left <= n;
         rsp_stall <= (n != 0);
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= (stall_left > 1);
      end
   end

   // watchdog on cycles without any accepted item or taken result
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("lru_slot_cache_directory_core_tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      mismatches = 0;
      send_no_gap = 1'b0;
      sink_no_stall = 1'b0;
      for (int t = 0; t < NUM_SLOTS; t++) dir_valid[t] = 1'b0;
      stamp_now = '0;
      last_key = '0;
      held_values = '0;
      hit_total = '0;
      miss_total = '0;
      insert_total = '0;
      limit_mb = LIMIT_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_limit_zero();
      set_limit(LIMIT_RESET);
      test_random();
      wait_drained();
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("lru_slot_cache_directory_core_tb passed");
      end else begin
         $display("lru_slot_cache_directory_core_tb failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
